FILE: sv/pcpfl_pkg.sv
// Shared definitions for the per-CPU page free-list allocator.
// Holds parameter defaults, reset values, codes and the controller/datapath structs.
// No dependencies.
package pcpfl_pkg;

	localparam int NUM_CPUS_DEF   = 8;
	localparam int MAX_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [31:0] FIRST_RESET = 32'h8000_0000;
	localparam logic [31:0] TOP_RESET   = 32'h8800_0000;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_TOP   = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_OOM = 2'd1;
	localparam logic [1:0] STAT_BAD = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic link;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic need_link;
	} sts_t;

endpackage

FILE: sv/per_cpu_page_free_list_allocator.sv
// Top level of the per-CPU page free-list allocator.
// Joins pcpfl_ctrl and pcpfl_dpath; depends on pcpfl_pkg.
//
//  Channel   Handshake            Payload
//  input     in_valid / in_stall  operation, cpu, page_addr
//  output    out_valid/ out_stall alloc_addr, status
//  config    cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A request executes against the list heads in the execute state, and the result is
// registered at its end. An allocate that finds a page then passes through the link
// state to write back the head from the link RAM read; a free or an out-of-memory
// allocate ends after execute. A new request is taken during the last cycle
// of the previous one.
// A stalled result register holds the next request in its execute cycle.
// Reset empties all lists and loads the default address window; no clearing pass.
module per_cpu_page_free_list_allocator #(
	parameter int NUM_CPUS   = pcpfl_pkg::NUM_CPUS_DEF,
	parameter int MAX_PAGES  = pcpfl_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = pcpfl_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [2:0]  cpu,
	input  logic [31:0] page_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] alloc_addr,
	output logic [1:0]  status
);
	import pcpfl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pcpfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcpfl_dpath #(
		.NUM_CPUS   (NUM_CPUS),
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.operation  (operation),
		.cpu        (cpu),
		.page_addr  (page_addr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.alloc_addr (alloc_addr),
		.status     (status),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

FILE: sv/pcpfl_ctrl.sv
// Controller of the per-CPU page free-list allocator.
// Sequences accept, execute and link write-back; depends on pcpfl_pkg.
module pcpfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  pcpfl_pkg::sts_t sts,
	output pcpfl_pkg::cmd_t cmd
);
	import pcpfl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept_ok;

	// A new request can be taken while the previous one finishes its last cycle.
	always_comb begin
		case (state_q)
			S_IDLE:  accept_ok = 1'b1;
			S_LINK:  accept_ok = 1'b1;
			S_EXEC:  accept_ok = sts.out_free && !sts.need_link;
			default: accept_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		if (in_valid && accept_ok) begin
			state_d = S_EXEC;
		end else begin
			case (state_q)
				S_IDLE:  state_d = S_IDLE;
				S_EXEC: begin
					if (!sts.out_free) begin
						state_d = S_EXEC;
					end else if (sts.need_link) begin
						state_d = S_LINK;
					end else begin
						state_d = S_IDLE;
					end
				end
				S_LINK:  state_d = S_IDLE;
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_stall  = !accept_ok;
		cmd.load  = in_valid && accept_ok;
		cmd.exec  = (state_q == S_EXEC) && sts.out_free;
		cmd.link  = (state_q == S_LINK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_link_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |=> (state_q != S_LINK))
		else $error("link write-back lasted more than one cycle");

	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !sts.out_free) |=> (state_q == S_EXEC))
		else $error("request left execute while the result register was blocked");

	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execute");

endmodule

FILE: sv/pcpfl_dpath.sv
// Datapath of the per-CPU page free-list allocator: config registers, list heads,
// link RAM, address checks and the result register. Depends on pcpfl_pkg.
module pcpfl_dpath #(
	parameter int NUM_CPUS   = pcpfl_pkg::NUM_CPUS_DEF,
	parameter int MAX_PAGES  = pcpfl_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = pcpfl_pkg::PAGE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            operation,
	input  logic [2:0]      cpu,
	input  logic [31:0]     page_addr,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     alloc_addr,
	output logic [1:0]      status,
	input  pcpfl_pkg::cmd_t cmd,
	output pcpfl_pkg::sts_t sts
);
	import pcpfl_pkg::*;

	localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int SLOT_W = $clog2(MAX_PAGES);
	localparam int LINK_W = $clog2(MAX_PAGES + 1);
	localparam int PB_SH  = $clog2(PAGE_BYTES);
	localparam logic [32:0] PB_MASK = 33'(PAGE_BYTES - 1);
	localparam logic [31:0] FIRST_RND_RST = 32'((33'(FIRST_RESET) + PB_MASK) & ~PB_MASK);

	// Configuration.
	logic [31:0] first_q;
	logic [31:0] first_rnd_q;
	logic [31:0] top_q;

	// Request registers.
	logic              op_q;
	logic [CPU_W-1:0]  cpu_q;
	logic [31:0]       pa_q;
	logic [4:0]        cpu_red;

	// List state.
	logic [LINK_W-1:0] head_q [NUM_CPUS];
	logic [LINK_W-1:0] link_mem [MAX_PAGES];
	logic [LINK_W-1:0] link_rdata_q;
	logic [CPU_W-1:0]  sel_q;

	// Result register.
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	logic [1:0]  out_status_q;

	logic [NUM_CPUS-1:0] nonempty;
	logic [CPU_W-1:0]    low_idx;
	logic [CPU_W-1:0]    sel_idx;
	logic [LINK_W-1:0]   head_sel;
	logic [SLOT_W-1:0]   rd_slot;
	logic                need_link;
	logic                out_free;

	logic [31:0]       diff;
	logic [63:0]       slot_ext;
	logic [SLOT_W-1:0] free_slot;
	logic              free_ok;
	logic              wr_en;
	logic              rd_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= FIRST_RESET;
			first_rnd_q <= FIRST_RND_RST;
			top_q       <= TOP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FIRST: begin
					first_q     <= cfg_data;
					first_rnd_q <= 32'((33'(cfg_data) + PB_MASK) & ~PB_MASK);
				end
				CFG_TOP:  top_q <= cfg_data;
				default:  top_q <= top_q;
			endcase
		end
	end

	// The processor number is folded into range by repeated subtraction.
	always_comb begin
		cpu_red = 5'(cpu);
		for (int i = 0; i < 4; i++) begin
			if (cpu_red >= 5'(NUM_CPUS)) begin
				cpu_red = cpu_red - 5'(NUM_CPUS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			cpu_q <= cpu_red[CPU_W-1:0];
			pa_q  <= page_addr;
		end
	end

	// Allocate: use the own list if it holds a page, else the lowest non-empty one.
	always_comb begin
		low_idx = '0;
		for (int i = 0; i < NUM_CPUS; i++) begin
			nonempty[i] = (head_q[i] != '0);
		end
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				low_idx = CPU_W'(i);
			end
		end
	end

	assign sel_idx   = nonempty[cpu_q] ? cpu_q : low_idx;
	assign head_sel  = head_q[sel_idx];
	assign rd_slot   = SLOT_W'(head_sel - LINK_W'(1));
	assign need_link = (op_q == OP_ALLOC) && (|nonempty);

	// Free: address must be page aligned, inside the window and inside the page table.
	assign diff      = pa_q - first_q;
	assign slot_ext  = 64'(diff >> PB_SH);
	assign free_slot = slot_ext[SLOT_W-1:0];
	assign free_ok   = (pa_q[PB_SH-1:0] == '0) && (pa_q >= first_q) && (pa_q < top_q)
		&& (slot_ext < 64'(MAX_PAGES));

	assign wr_en = cmd.exec && (op_q == OP_FREE) && free_ok;
	assign rd_en = cmd.exec && need_link;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[free_slot] <= head_q[cpu_q];
		end
		if (rd_en) begin
			link_rdata_q <= link_mem[rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sel_q <= sel_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= '0;
			end
		end else if (wr_en) begin
			head_q[cpu_q] <= LINK_W'(free_slot) + LINK_W'(1);
		end else if (cmd.link) begin
			head_q[sel_q] <= link_rdata_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == OP_FREE) begin
				out_addr_q   <= '0;
				out_status_q <= free_ok ? STAT_OK : STAT_BAD;
			end else if (need_link) begin
				out_addr_q   <= first_rnd_q + 32'(64'(rd_slot) << PB_SH);
				out_status_q <= STAT_OK;
			end else begin
				out_addr_q   <= '0;
				out_status_q <= STAT_OOM;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_addr    = out_addr_q;
	assign status        = out_status_q;
	assign sts.out_free  = out_free;
	assign sts.need_link = need_link;

	a_link_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> out_valid_q)
		else $error("link write-back without a pending allocate result");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed request produced no result");

	a_oom_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_ALLOC && !need_link)
		|=> (out_status_q == STAT_OOM && out_addr_q == '0))
		else $error("allocate with all lists empty did not report out of memory");

endmodule

FILE: tb/sv/tb_per_cpu_page_free_list_allocator.sv
// Self-checking testbench for the per-CPU page free-list allocator.
// A built-in predictor tracks list heads, links and the address window; depends on pcpfl_pkg
// and per_cpu_page_free_list_allocator.
module tb_per_cpu_page_free_list_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import pcpfl_pkg::*;

	localparam int unsigned CPUS = NUM_CPUS_DEF;
	localparam int unsigned PAGES = MAX_PAGES_DEF;
	localparam int unsigned PAGE = PAGE_BYTES_DEF;
	localparam int IDLE_PCT = 9;
	localparam int HOLD_CYCLES = 300;
	localparam int CHUNK_ITEMS = 85;

	typedef struct {
		logic        op;
		logic [2:0]  cpu;
		logic [31:0] addr;
	} page_req_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  st;
	} page_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [2:0]  cpu = '0;
	logic [31:0] page_addr = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] alloc_addr;
	logic [1:0]  status;

	// Predictor state: slot+1 of each list top, and the link of every slot.
	bit [15:0]   list_top [CPUS];
	bit [15:0]   link_mem [PAGES];
	logic [31:0] win_first = FIRST_RESET;
	logic [31:0] win_top = TOP_RESET;

	page_req_t    pending_reqs[$];
	page_result_t predicted_results[$];
	// Pages handed out under the current first_address, safe to free again.
	logic [31:0]  returned_pages[$];
	// Slots that were ever pushed; a fresh free never picks one of these.
	bit           slot_taken [PAGES];

	bit quiet = 1'b0;
	bit hold_on = 1'b0;
	int hold_count = 0;
	int bad_results = 0;

	per_cpu_page_free_list_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.cpu(cpu),
		.page_addr(page_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.alloc_addr(alloc_addr),
		.status(status)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned page_ceil(input logic [31:0] a);
		return ((64'(a) + PAGE - 1) / PAGE) * PAGE;
	endfunction

	// Returns 1 when the address is a legal free under the current window.
	function automatic bit free_slot(input logic [31:0] pa, output int unsigned slot);
		slot = 0;
		if ((pa % PAGE) != 0 || pa < win_first || pa >= win_top)
			return 1'b0;
		slot = (pa - win_first) / PAGE;
		return slot < PAGES;
	endfunction

	function automatic bit pop_page(input int unsigned c, output logic [31:0] addr);
		int unsigned slot;
		addr = '0;
		if (list_top[c] == 0)
			return 1'b0;
		slot = list_top[c] - 1;
		list_top[c] = link_mem[slot];
		// The page address is rebuilt from the slot with the current base.
		addr = 32'(page_ceil(win_first) + 64'(slot) * PAGE);
		return 1'b1;
	endfunction

	function automatic page_result_t predict_page(input page_req_t req);
		page_result_t r;
		int unsigned slot;
		bit got;
		int unsigned k;
		r.addr = '0;
		r.st = STAT_OK;
		if (req.op == OP_FREE) begin
			if (free_slot(req.addr, slot)) begin
				link_mem[slot] = list_top[req.cpu];
				list_top[req.cpu] = 16'(slot + 1);
			end else begin
				r.st = STAT_BAD;
			end
		end else begin
			got = pop_page(req.cpu, r.addr);
			for (k = 0; k < CPUS && !got; k++)
				got = pop_page(k, r.addr);
			if (!got) begin
				r.addr = '0;
				r.st = STAT_OOM;
			end
		end
		return r;
	endfunction

	// Request driver: holds a stalled transaction, otherwise offers the next one or idles.
	always @(posedge clk) begin : drive_requests
		page_result_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				r = predict_page(pending_reqs[0]);
				predicted_results.push_back(r);
				if (pending_reqs[0].op == OP_ALLOC && r.st == STAT_OK)
					returned_pages.push_back(r.addr);
				void'(pending_reqs.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					operation <= pending_reqs[0].op;
					cpu <= pending_reqs[0].cpu;
					page_addr <= pending_reqs[0].addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side stall: one long hold-off, otherwise random except in the quiet chunk.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_on && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin : check_results
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: addr %h status %0d", alloc_addr, status);
			end else begin
				want = predicted_results.pop_front();
				if (alloc_addr !== want.addr || status !== want.st) begin
					bad_results++;
					if (bad_results <= 10)
						$display("mismatch: addr exp %h got %h, status exp %0d got %0d",
							want.addr, alloc_addr, want.st, status);
				end
			end
		end
	end

	task automatic queue_item(input logic op, input logic [2:0] c, input logic [31:0] pa);
		page_req_t req;
		int unsigned s;
		if (op == OP_FREE && free_slot(pa, s))
			slot_taken[s] = 1'b1;
		req.op = op;
		req.cpu = c;
		req.addr = pa;
		pending_reqs.push_back(req);
	endtask

	function automatic bit pick_fresh(output logic [31:0] pa);
		longint unsigned base;
		longint unsigned span;
		int unsigned j;
		int n;
		base = page_ceil(win_first);
		span = (64'(win_top) > base) ? (64'(win_top) - base + PAGE - 1) / PAGE : 0;
		if (span == 0 || span > PAGES)
			span = PAGES;
		pa = '0;
		for (n = 0; n < 8; n++) begin
			j = $urandom_range(int'(span) - 1);
			if (!slot_taken[j]) begin
				pa = 32'(base + 64'(j) * PAGE);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic drain();
		@(negedge clk);
		while (pending_reqs.size() != 0 || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FIRST) begin
			win_first = val;
			// Returned addresses map to other slots once the base moves.
			returned_pages.delete();
		end else begin
			win_top = val;
		end
	endtask

	task automatic random_window();
		logic [31:0] f;
		logic [31:0] t;
		f = $urandom;
		case ($urandom_range(3))
			0: begin
				f = f & ~(PAGE - 1);
				t = f + $urandom_range(1, 40) * PAGE;
			end
			1: t = f + $urandom_range(1, PAGES + 40) * PAGE;
			2: t = 32'hFFFF_FFFF;
			default: t = $urandom;
		endcase
		write_reg(CFG_FIRST, f);
		write_reg(CFG_TOP, t);
	endtask

	task automatic gen_items(input int n);
		int k;
		int idx;
		logic [2:0] c;
		logic [31:0] pa;
		int unsigned s;
		int r;
		for (k = 0; k < n; k++) begin
			@(negedge clk);
			while (pending_reqs.size() >= 4)
				@(negedge clk);
			r = $urandom_range(99);
			c = 3'($urandom_range(7));
			if (r < 44) begin
				queue_item(OP_ALLOC, c, $urandom);
			end else if (r < 84) begin
				if (returned_pages.size() != 0 && $urandom_range(1)) begin
					idx = $urandom_range(returned_pages.size() - 1);
					pa = returned_pages[idx];
					returned_pages.delete(idx);
					queue_item(OP_FREE, c, pa);
				end else if (pick_fresh(pa)) begin
					queue_item(OP_FREE, c, pa);
				end else begin
					queue_item(OP_ALLOC, c, $urandom);
				end
			end else begin
				case ($urandom_range(3))
					0: pa = $urandom;
					1: pa = (win_first & ~(PAGE - 1)) + $urandom_range(64) * PAGE
						+ $urandom_range(1, PAGE - 1);
					2: pa = win_top & ~(PAGE - 1);
					default: pa = (win_first & ~(PAGE - 1)) - PAGE;
				endcase
				// Never push a slot that may already sit on a list.
				if (free_slot(pa, s) && slot_taken[s])
					pa[0] = 1'b1;
				queue_item(OP_FREE, c, pa);
			end
		end
	endtask

	initial begin : stimulus
		int ch;
		logic [31:0] pa_a;
		logic [31:0] pa_b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default window: empty lists, window edges, stealing and a double free.
		queue_item(OP_ALLOC, 3'd0, 32'h0);
		queue_item(OP_FREE, 3'd0, 32'h8000_0000);
		queue_item(OP_FREE, 3'd7, 32'h87FF_F000);
		queue_item(OP_FREE, 3'd1, 32'h8800_0000);
		queue_item(OP_FREE, 3'd1, 32'h7FFF_F000);
		queue_item(OP_FREE, 3'd1, 32'h8000_0001);
		queue_item(OP_FREE, 3'd7, 32'hFFFF_FFFF);
		queue_item(OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
		queue_item(OP_ALLOC, 3'd7, 32'h0);
		queue_item(OP_ALLOC, 3'd3, 32'h0);
		queue_item(OP_FREE, 3'd2, 32'h8000_5000);
		queue_item(OP_FREE, 3'd2, 32'h8000_6000);
		queue_item(OP_FREE, 3'd3, 32'h8000_5000);
		queue_item(OP_ALLOC, 3'd3, 32'h0);
		queue_item(OP_ALLOC, 3'd2, 32'h0);
		queue_item(OP_ALLOC, 3'd2, 32'h0);
		queue_item(OP_ALLOC, 3'd2, 32'h0);
		drain();

		// Window at the very top; then the base moves so the rebuilt address wraps.
		write_reg(CFG_FIRST, 32'hFFFF_F000);
		write_reg(CFG_TOP, 32'hFFFF_FFFF);
		queue_item(OP_FREE, 3'd6, 32'hFFFF_F000);
		queue_item(OP_FREE, 3'd1, 32'hFFFF_E000);
		drain();
		write_reg(CFG_FIRST, 32'hFFFF_F001);
		queue_item(OP_ALLOC, 3'd6, 32'h0);
		drain();

		// Empty window, then a window wider than the page table.
		write_reg(CFG_FIRST, 32'h0);
		write_reg(CFG_TOP, 32'h0);
		queue_item(OP_FREE, 3'd0, 32'h0);
		drain();
		write_reg(CFG_TOP, 32'hFFFF_FFFF);
		queue_item(OP_FREE, 3'd4, 32'h0800_0000);
		queue_item(OP_FREE, 3'd4, 32'h07FF_F000);
		queue_item(OP_ALLOC, 3'd0, 32'h0);
		drain();

		for (ch = 0; ch < 8; ch++) begin
			drain();
			if (ch == 0) begin
				write_reg(CFG_FIRST, FIRST_RESET);
				write_reg(CFG_TOP, TOP_RESET);
			end else begin
				random_window();
			end
			returned_pages.delete();
			quiet = (ch == 2);
			if (ch == 1)
				hold_on = 1'b1;
			gen_items(CHUNK_ITEMS);
		end
		drain();
		quiet = 1'b0;

		// A page pushed twice onto one list links to itself and is handed out forever.
		write_reg(CFG_FIRST, FIRST_RESET);
		write_reg(CFG_TOP, TOP_RESET);
		if (!pick_fresh(pa_a))
			pa_a = 32'h8000_0000;
		queue_item(OP_FREE, 3'd5, pa_a);
		queue_item(OP_FREE, 3'd5, pa_a);
		queue_item(OP_ALLOC, 3'd5, 32'h0);
		queue_item(OP_ALLOC, 3'd5, 32'h0);
		queue_item(OP_ALLOC, 3'd5, 32'h0);
		if (pick_fresh(pa_b))
			queue_item(OP_FREE, 3'd1, pa_b);
		queue_item(OP_ALLOC, 3'd1, 32'h0);
		queue_item(OP_ALLOC, 3'd1, 32'h0);
		drain();

		repeat (20) @(posedge clk);
		if (bad_results == 0 && predicted_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
sv/pcpfl_pkg.sv
sv/pcpfl_ctrl.sv
sv/pcpfl_dpath.sv
sv/per_cpu_page_free_list_allocator.sv
tb/sv/tb_per_cpu_page_free_list_allocator.sv
